// ----- rtl/quaternion_to_euler_mounting_assert.svh -----
// Assertion macros for the quaternion to Euler block.
// Used by the top level; expects clk and rst in scope.
`ifndef QUATERNION_TO_EULER_MOUNTING_ASSERT_SVH
`define QUATERNION_TO_EULER_MOUNTING_ASSERT_SVH

// Same-cycle implication
`define QTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qte_pkg.sv -----
// Shared types, constants and the arctangent table for the quaternion
// to Euler block. No dependencies.
`timescale 1ns / 1ps

package qte_pkg;

  // Datapath widths
  localparam int SW = 34;  // sums of products
  localparam int CW = 36;  // CORDIC x and y
  localparam int ZW = 30;  // angle in 2^-20 degree

  // Sequencer counts (last index of each loop)
  localparam logic [5:0] MUL_LAST  = 6'd9;
  localparam logic [5:0] DIV_LAST  = 6'd29;
  localparam logic [5:0] SQRT_LAST = 6'd30;

  localparam logic signed [ZW-1:0] DEG90       = 30'sd94371840;
  localparam logic signed [14:0]   ANGLE_LIMIT = 15'sd11520;
  localparam logic signed [14:0]   RIGHT_ANGLE = 15'sd5760;

  // Configuration register indexes
  localparam logic [2:0] REG_AXIS_ORDER  = 3'd0;
  localparam logic [2:0] REG_FLIP_ROLL   = 3'd1;
  localparam logic [2:0] REG_FLIP_PITCH  = 3'd2;
  localparam logic [2:0] REG_FLIP_YAW    = 3'd3;
  localparam logic [2:0] REG_INVERT_BAND = 3'd4;

  // Axis order codes
  localparam logic [2:0] AX_XYZ = 3'd0;
  localparam logic [2:0] AX_XZY = 3'd1;
  localparam logic [2:0] AX_YXZ = 3'd2;
  localparam logic [2:0] AX_YZX = 3'd3;
  localparam logic [2:0] AX_ZXY = 3'd4;
  localparam logic [2:0] AX_ZYX = 3'd5;

  typedef enum logic [3:0] {
    PH_IDLE, PH_MUL, PH_SUM, PH_CINIT, PH_CSTEP, PH_CSAVE,
    PH_DINIT, PH_DSTEP, PH_SQ, PH_RINIT, PH_RSTEP, PH_OUT
  } phase_t;

  typedef enum logic [1:0] {ANG_YAW, ANG_ROLL, ANG_PITCH} ang_t;

  typedef struct packed {
    logic       load;
    phase_t     phase;
    ang_t       ang;
    logic [5:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic pitch_sat;
  } status_t;

  typedef struct packed {
    logic [2:0]  axis_order;
    logic        flip_roll;
    logic        flip_pitch;
    logic        flip_yaw;
    logic [10:0] invert_band;
  } cfg_t;

  // atan(2^-i) in 2^-20 degree
  function automatic logic signed [ZW-1:0] atan_angle(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:  a = 30'sd47185920;
      5'd1:  a = 30'sd27855475;
      5'd2:  a = 30'sd14718068;
      5'd3:  a = 30'sd7471121;
      5'd4:  a = 30'sd3750058;
      5'd5:  a = 30'sd1876857;
      5'd6:  a = 30'sd938658;
      5'd7:  a = 30'sd469357;
      5'd8:  a = 30'sd234682;
      5'd9:  a = 30'sd117342;
      5'd10: a = 30'sd58671;
      5'd11: a = 30'sd29335;
      5'd12: a = 30'sd14668;
      5'd13: a = 30'sd7334;
      5'd14: a = 30'sd3667;
      5'd15: a = 30'sd1833;
      5'd16: a = 30'sd917;
      5'd17: a = 30'sd458;
      5'd18: a = 30'sd229;
      5'd19: a = 30'sd115;
      5'd20: a = 30'sd57;
      5'd21: a = 30'sd29;
      5'd22: a = 30'sd14;
      5'd23: a = 30'sd7;
      5'd24: a = 30'sd4;
      5'd25: a = 30'sd2;
      5'd26: a = 30'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Round to 1/64 degree (half up) and clamp
  function automatic logic signed [14:0] to_out(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] t;
    logic signed [16:0] r;
    logic signed [14:0] o;
    t = {z[ZW-1], z} + 31'sd8192;
    r = t[ZW:14];
    if (r > 17'sd11520) begin
      o = ANGLE_LIMIT;
    end else if (r < -17'sd11520) begin
      o = -ANGLE_LIMIT;
    end else begin
      o = r[14:0];
    end
    return o;
  endfunction

endpackage

// ----- rtl/qte_ctrl.sv -----
// Sequencer for the quaternion to Euler datapath.
// Depends on qte_pkg for command, status and phase types.
`timescale 1ns / 1ps

module qte_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  qte_pkg::status_t status,
  output qte_pkg::cmd_t    cmd
);

  localparam int CSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam logic [5:0] CLAST = 6'(CSTEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_CINIT, S_CSTEP, S_CSAVE,
    S_DINIT, S_DSTEP, S_SQ, S_RINIT, S_RSTEP, S_OUT
  } state_t;

  state_t        state;
  logic [5:0]    cnt;
  qte_pkg::ang_t ang;
  logic          out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Sequence one item and hold the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ang       <= qte_pkg::ANG_YAW;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
            cnt   <= '0;
          end
        end
        S_MUL: begin
          if (cnt == qte_pkg::MUL_LAST) begin
            state <= S_SUM;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_SUM: begin
          state <= S_CINIT;
          ang   <= qte_pkg::ANG_YAW;
        end
        S_CINIT: begin
          state <= S_CSTEP;
          cnt   <= '0;
        end
        S_CSTEP: begin
          if (cnt == CLAST) begin
            state <= S_CSAVE;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_CSAVE: begin
          case (ang)
            qte_pkg::ANG_YAW: begin
              ang   <= qte_pkg::ANG_ROLL;
              state <= S_CINIT;
            end
            qte_pkg::ANG_ROLL: state <= S_DINIT;
            default: state <= S_OUT;
          endcase
        end
        S_DINIT: begin
          if (status.pitch_sat) begin
            state <= S_OUT;
          end else begin
            state <= S_DSTEP;
            cnt   <= '0;
          end
        end
        S_DSTEP: begin
          if (cnt == qte_pkg::DIV_LAST) begin
            state <= S_SQ;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_SQ: state <= S_RINIT;
        S_RINIT: begin
          state <= S_RSTEP;
          cnt   <= '0;
        end
        S_RSTEP: begin
          if (cnt == qte_pkg::SQRT_LAST) begin
            state <= S_CINIT;
            ang   <= qte_pkg::ANG_PITCH;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Decode commands
  always_comb begin
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.ang  = ang;
    cmd.cnt  = cnt;
    case (state)
      S_MUL:   cmd.phase = qte_pkg::PH_MUL;
      S_SUM:   cmd.phase = qte_pkg::PH_SUM;
      S_CINIT: cmd.phase = qte_pkg::PH_CINIT;
      S_CSTEP: cmd.phase = qte_pkg::PH_CSTEP;
      S_CSAVE: cmd.phase = qte_pkg::PH_CSAVE;
      S_DINIT: cmd.phase = qte_pkg::PH_DINIT;
      S_DSTEP: cmd.phase = qte_pkg::PH_DSTEP;
      S_SQ:    cmd.phase = qte_pkg::PH_SQ;
      S_RINIT: cmd.phase = qte_pkg::PH_RINIT;
      S_RSTEP: cmd.phase = qte_pkg::PH_RSTEP;
      S_OUT:   cmd.phase = out_free ? qte_pkg::PH_OUT : qte_pkg::PH_IDLE;
      default: cmd.phase = qte_pkg::PH_IDLE;
    endcase
  end

endmodule

// ----- rtl/qte_dp.sv -----
// Datapath: shared multiplier, CORDIC vectoring unit, restoring divider,
// integer square root and the mounting/hysteresis output stage. Uses qte_pkg.
`timescale 1ns / 1ps

module qte_dp (
  input  logic                clk,
  input  logic                rst,
  input  qte_pkg::cmd_t       cmd,
  input  qte_pkg::cfg_t       cfg,
  input  logic signed [15:0]  quat_real,
  input  logic signed [15:0]  quat_i,
  input  logic signed [15:0]  quat_j,
  input  logic signed [15:0]  quat_k,
  output qte_pkg::status_t    status,
  output logic signed [14:0]  roll_angle,
  output logic signed [14:0]  pitch_angle,
  output logic signed [14:0]  yaw_angle,
  output logic signed [14:0]  heading_angle,
  output logic                upside_down
);

  localparam int SW = qte_pkg::SW;
  localparam int CW = qte_pkg::CW;
  localparam int ZW = qte_pkg::ZW;

  logic signed [15:0] q_r, q_i, q_j, q_k;
  logic signed [15:0] ma, mb;
  logic signed [31:0] prod [10];
  logic signed [SW-1:0] ext [10];
  logic signed [SW-1:0] sum_yn, sum_yd, sum_pa, sum_n, sum_rn, sum_rd;
  logic [SW-1:0] mag, nu;
  logic signed [14:0] pitch_sat_val;

  logic signed [CW-1:0] cx, cy, x, y, xs, ys, s36;
  logic signed [ZW-1:0] z;
  logic czero;
  logic signed [14:0] zr;
  logic signed [14:0] ang_yaw, ang_roll, ang_pitch;

  logic [SW-1:0] rem, rem2;
  logic [29:0]   quo;
  logic [59:0]   sq;
  logic [60:0]   rv, rr, rbit, tsum;

  logic inv_flag;
  logic signed [14:0] mr, mp, my, fr, fp, fy;
  logic signed [13:0] h, thr;
  logic signed [15:0] mr16, mp16, thr16;
  logic inv;

  // Multiplier operand select
  always_comb begin
    case (cmd.cnt[3:0])
      4'd0: begin ma = q_r; mb = q_r; end
      4'd1: begin ma = q_i; mb = q_i; end
      4'd2: begin ma = q_j; mb = q_j; end
      4'd3: begin ma = q_k; mb = q_k; end
      4'd4: begin ma = q_i; mb = q_j; end
      4'd5: begin ma = q_k; mb = q_r; end
      4'd6: begin ma = q_i; mb = q_k; end
      4'd7: begin ma = q_j; mb = q_r; end
      4'd8: begin ma = q_j; mb = q_k; end
      default: begin ma = q_i; mb = q_r; end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      ext[k] = SW'(prod[k]);
    end
  end

  // Pitch saturation check
  assign mag = sum_pa[SW-1] ? $unsigned(-sum_pa) : $unsigned(sum_pa);
  assign nu  = $unsigned(sum_n);
  assign status.pitch_sat = (sum_n == '0) || (mag >= nu);
  assign pitch_sat_val = (sum_n == '0) ? 15'sd0 :
                         (sum_pa[SW-1] ? -qte_pkg::RIGHT_ANGLE : qte_pkg::RIGHT_ANGLE);

  // CORDIC operand select
  assign s36 = $signed({6'b0, quo});
  always_comb begin
    case (cmd.ang)
      qte_pkg::ANG_YAW: begin
        cy = CW'(sum_yn);
        cx = CW'(sum_yd);
      end
      qte_pkg::ANG_ROLL: begin
        cy = CW'(sum_rn);
        cx = CW'(sum_rd);
      end
      default: begin
        cy = sum_pa[SW-1] ? -s36 : s36;
        cx = $signed({5'b0, rr[30:0]});
      end
    endcase
  end

  assign xs   = x >>> cmd.cnt[4:0];
  assign ys   = y >>> cmd.cnt[4:0];
  assign zr   = czero ? 15'sd0 : qte_pkg::to_out(z);
  assign rem2 = {rem[SW-2:0], 1'b0};
  assign tsum = rr + rbit;

  // Permute, flip and judge inversion
  always_comb begin
    case (cfg.axis_order)
      qte_pkg::AX_XZY: begin mr = ang_roll;  mp = ang_yaw;   my = ang_pitch; end
      qte_pkg::AX_YXZ: begin mr = ang_pitch; mp = ang_roll;  my = ang_yaw;   end
      qte_pkg::AX_YZX: begin mr = ang_pitch; mp = ang_yaw;   my = ang_roll;  end
      qte_pkg::AX_ZXY: begin mr = ang_yaw;   mp = ang_roll;  my = ang_pitch; end
      qte_pkg::AX_ZYX: begin mr = ang_yaw;   mp = ang_pitch; my = ang_roll;  end
      default:         begin mr = ang_roll;  mp = ang_pitch; my = ang_yaw;   end
    endcase
    fr    = cfg.flip_roll  ? -mr : mr;
    fp    = cfg.flip_pitch ? -mp : mp;
    fy    = cfg.flip_yaw   ? -my : my;
    h     = inv_flag ? -$signed({3'b0, cfg.invert_band}) : $signed({3'b0, cfg.invert_band});
    thr   = 14'sd5760 + h;
    mr16  = {fr[14], fr};
    mp16  = {fp[14], fp};
    thr16 = {{2{thr[13]}}, thr};
    inv   = (mr16 > thr16) || (mr16 < -thr16) || (mp16 > thr16) || (mp16 < -thr16);
  end

  // Keep the inversion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_flag <= 1'b0;
    end else if (cmd.phase == qte_pkg::PH_OUT) begin
      inv_flag <= inv;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r <= quat_real;
      q_i <= quat_i;
      q_j <= quat_j;
      q_k <= quat_k;
    end
    case (cmd.phase)
      qte_pkg::PH_MUL: prod[cmd.cnt[3:0]] <= ma * mb;
      qte_pkg::PH_SUM: begin
        sum_yn <= (ext[4] + ext[5]) <<< 1;
        sum_yd <= ext[1] - ext[2] - ext[3] + ext[0];
        sum_pa <= (ext[7] - ext[6]) <<< 1;
        sum_n  <= ext[0] + ext[1] + ext[2] + ext[3];
        sum_rn <= (ext[8] + ext[9]) <<< 1;
        sum_rd <= ext[3] + ext[0] - ext[1] - ext[2];
      end
      qte_pkg::PH_CINIT: begin
        czero <= (cx == '0) && (cy == '0);
        if (cx[CW-1]) begin
          if (!cy[CW-1]) begin
            x <= cy;
            y <= -cx;
            z <= qte_pkg::DEG90;
          end else begin
            x <= -cy;
            y <= cx;
            z <= -qte_pkg::DEG90;
          end
        end else begin
          x <= cx;
          y <= cy;
          z <= '0;
        end
      end
      qte_pkg::PH_CSTEP: begin
        if (!y[CW-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + qte_pkg::atan_angle(cmd.cnt[4:0]);
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - qte_pkg::atan_angle(cmd.cnt[4:0]);
        end
      end
      qte_pkg::PH_CSAVE: begin
        case (cmd.ang)
          qte_pkg::ANG_YAW:  ang_yaw  <= zr;
          qte_pkg::ANG_ROLL: ang_roll <= zr;
          default:           ang_pitch <= zr;
        endcase
      end
      qte_pkg::PH_DINIT: begin
        rem       <= mag;
        quo       <= '0;
        ang_pitch <= pitch_sat_val;
      end
      qte_pkg::PH_DSTEP: begin
        if (rem2 >= nu) begin
          rem <= rem2 - nu;
          quo <= {quo[28:0], 1'b1};
        end else begin
          rem <= rem2;
          quo <= {quo[28:0], 1'b0};
        end
      end
      qte_pkg::PH_SQ: sq <= quo * quo;
      qte_pkg::PH_RINIT: begin
        rv   <= (61'd1 << 60) - {1'b0, sq};
        rr   <= '0;
        rbit <= 61'd1 << 60;
      end
      qte_pkg::PH_RSTEP: begin
        if (rv >= tsum) begin
          rv <= rv - tsum;
          rr <= (rr >> 1) + rbit;
        end else begin
          rr <= rr >> 1;
        end
        rbit <= rbit >> 2;
      end
      qte_pkg::PH_OUT: begin
        roll_angle    <= fr;
        pitch_angle   <= fp;
        yaw_angle     <= fy;
        heading_angle <= inv ? -fy : fy;
        upside_down   <= inv;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/quaternion_to_euler_mounting.sv -----
// Quaternion to mounted Euler angles, one item at a time.
// The shared CORDIC unit finds yaw, then roll, then pitch; pitch first passes through
// the 30-step divider and the 31-step square root. When pitch saturates, the divider,
// the square root and the pitch CORDIC pass are skipped. A new item is taken only when idle.
// Synchronous active-high reset clears control and the inversion flag and sets config to defaults.
`timescale 1ns / 1ps
`include "quaternion_to_euler_mounting_assert.svh"

module quaternion_to_euler_mounting #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] quat_real,
  input  logic signed [15:0] quat_i,
  input  logic signed [15:0] quat_j,
  input  logic signed [15:0] quat_k,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [14:0] yaw_angle,
  output logic signed [14:0] heading_angle,
  output logic               upside_down,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  qte_pkg::cfg_t    cfg;
  qte_pkg::cmd_t    cmd;
  qte_pkg::status_t status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_order  <= '0;
      cfg.flip_roll   <= 1'b0;
      cfg.flip_pitch  <= 1'b0;
      cfg.flip_yaw    <= 1'b0;
      cfg.invert_band <= 11'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        qte_pkg::REG_AXIS_ORDER:  cfg.axis_order  <= cfg_data[2:0];
        qte_pkg::REG_FLIP_ROLL:   cfg.flip_roll   <= cfg_data[0];
        qte_pkg::REG_FLIP_PITCH:  cfg.flip_pitch  <= cfg_data[0];
        qte_pkg::REG_FLIP_YAW:    cfg.flip_yaw    <= cfg_data[0];
        qte_pkg::REG_INVERT_BAND: cfg.invert_band <= cfg_data;
        default: ;
      endcase
    end
  end

  qte_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  qte_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .quat_real     (quat_real),
    .quat_i        (quat_i),
    .quat_j        (quat_j),
    .quat_k        (quat_k),
    .status        (status),
    .roll_angle    (roll_angle),
    .pitch_angle   (pitch_angle),
    .yaw_angle     (yaw_angle),
    .heading_angle (heading_angle),
    .upside_down   (upside_down)
  );

  // Checks
  `QTE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted item left block idle")
  `QTE_ASSERT_NOW(a_heading_sign, out_valid, heading_angle == (upside_down ? -yaw_angle : yaw_angle), "heading sign mismatch")
  `QTE_ASSERT_NOW(a_idle_on_result, $rose(out_valid), !in_stall, "result shown while still busy")

endmodule

// ----- tb/tb_quaternion_to_euler_mounting.sv -----
// Testbench for quaternion_to_euler_mounting: drives quaternions, predicts the mounted angles,
// heading and inversion flag in SystemVerilog, and checks every result in order.
// Depends on qte_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_quaternion_to_euler_mounting;

  typedef struct {
    logic signed [14:0] roll;
    logic signed [14:0] pitch;
    logic signed [14:0] yaw;
    logic signed [14:0] head;
    logic               inv;
  } mount_t;

  localparam longint QUARTER_TURN = 64'sd94371840;
  localparam int     WATCHDOG_LIMIT = 6000;
  localparam int     SETTLE_CYCLES  = 200;

  // atan(2^-i) in 2^-20 degree
  localparam longint ARC_STEP [16] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] quat_real, quat_i, quat_j, quat_k;
  logic               out_valid;
  logic               out_stall;
  logic signed [14:0] roll_angle, pitch_angle, yaw_angle, heading_angle;
  logic               upside_down;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [10:0]        cfg_data;

  // predictor copy of the configuration and the inversion state
  logic [2:0]  m_axis;
  logic        m_flip_roll, m_flip_pitch, m_flip_yaw;
  logic [10:0] m_band;
  logic        m_inverted;

  mount_t expected_mounts[$];
  int     errors;
  int     sent_items;
  int     checked_items;
  int     config_writes;
  int     idle_cycles;
  bit     quiet_sender;
  bit     quiet_receiver;

  quaternion_to_euler_mounting u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .quat_real(quat_real), .quat_i(quat_i), .quat_j(quat_j), .quat_k(quat_k),
    .out_valid(out_valid), .out_stall(out_stall),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .heading_angle(heading_angle), .upside_down(upside_down),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Vectoring CORDIC: angle of (x, y) in 2^-20 degree
  function automatic longint vector_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        z = QUARTER_TURN;
        t = x; x = y; y = -t;
      end else begin
        z = -QUARTER_TURN;
        t = x; x = -y; y = t;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ARC_STEP[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ARC_STEP[i];
      end
    end
    return z;
  endfunction

  // Round to 1/64 degree, half up, and clamp
  function automatic longint to_sixtyfourths(longint z);
    longint r;
    r = (z + 8192) >>> 14;
    if (r > 11520) r = 11520;
    if (r < -11520) r = -11520;
    return r;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint tilt_angle(longint a, longint n);
    longint unsigned mag, s, c;
    if (n <= 0) return 0;
    mag = (a < 0) ? -a : a;
    if (mag >= n) return (a < 0) ? -5760 : 5760;
    s = (mag << 30) / n;
    c = floor_sqrt((64'd1 << 60) - s * s);
    return to_sixtyfourths(vector_angle((a < 0) ? -longint'(s) : longint'(s), longint'(c)));
  endfunction

  // Compute the mounted result of one quaternion and advance the inversion state
  function automatic mount_t predict_mount(logic signed [15:0] qr, logic signed [15:0] qi,
                                           logic signed [15:0] qj, logic signed [15:0] qk);
    longint r, i, j, k, sr, si, sj, sk, yw, pt, rl, mr, mp, my, h;
    mount_t m;
    r = qr; i = qi; j = qj; k = qk;
    sr = r * r; si = i * i; sj = j * j; sk = k * k;
    yw = to_sixtyfourths(vector_angle(2 * (i * j + k * r), si - sj - sk + sr));
    pt = tilt_angle(-2 * (i * k - j * r), si + sj + sk + sr);
    rl = to_sixtyfourths(vector_angle(2 * (j * k + i * r), -si - sj + sk + sr));
    case (m_axis)
      qte_pkg::AX_XZY: begin mr = rl; mp = yw; my = pt; end
      qte_pkg::AX_YXZ: begin mr = pt; mp = rl; my = yw; end
      qte_pkg::AX_YZX: begin mr = pt; mp = yw; my = rl; end
      qte_pkg::AX_ZXY: begin mr = yw; mp = rl; my = pt; end
      qte_pkg::AX_ZYX: begin mr = yw; mp = pt; my = rl; end
      default: begin mr = rl; mp = pt; my = yw; end
    endcase
    if (m_flip_roll) mr = -mr;
    if (m_flip_pitch) mp = -mp;
    if (m_flip_yaw) my = -my;
    h = m_inverted ? -longint'(m_band) : longint'(m_band);
    m_inverted = (mr > 5760 + h) || (mr < -5760 - h) || (mp > 5760 + h) || (mp < -5760 - h);
    m.roll  = mr[14:0];
    m.pitch = mp[14:0];
    m.yaw   = my[14:0];
    m.head  = m_inverted ? -my[14:0] : my[14:0];
    m.inv   = m_inverted;
    return m;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int gap_cycles();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one item and record its expected result on acceptance
  task automatic send_quat(logic signed [15:0] qr, logic signed [15:0] qi,
                           logic signed [15:0] qj, logic signed [15:0] qk);
    int g;
    g = quiet_sender ? 0 : gap_cycles();
    repeat (g) @(negedge clk);
    quat_real = qr; quat_i = qi; quat_j = qj; quat_k = qk;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_mounts.push_back(predict_mount(qr, qi, qj, qk));
    sent_items++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Quaternion from roll, pitch, yaw in degrees, scaled by mag
  task automatic send_euler(real rdeg, real pdeg, real ydeg, real mag);
    real cr, sr, cp, sp, cy, sy, v[4];
    logic signed [15:0] q[4];
    cr = $cos(rdeg * 3.14159265358979 / 360.0); sr = $sin(rdeg * 3.14159265358979 / 360.0);
    cp = $cos(pdeg * 3.14159265358979 / 360.0); sp = $sin(pdeg * 3.14159265358979 / 360.0);
    cy = $cos(ydeg * 3.14159265358979 / 360.0); sy = $sin(ydeg * 3.14159265358979 / 360.0);
    v[0] = cr * cp * cy + sr * sp * sy;
    v[1] = sr * cp * cy - cr * sp * sy;
    v[2] = cr * sp * cy + sr * cp * sy;
    v[3] = cr * cp * sy - sr * sp * cy;
    for (int n = 0; n < 4; n++) begin
      v[n] = v[n] * mag;
      if (v[n] > 32767.0) v[n] = 32767.0;
      if (v[n] < -32768.0) v[n] = -32768.0;
      q[n] = 16'($rtoi(v[n]));
    end
    send_quat(q[0], q[1], q[2], q[3]);
  endtask

  // Wait until all results are back and the block has settled
  task automatic drain();
    while (expected_mounts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] value);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = value;
    @(posedge clk);
    case (idx)
      qte_pkg::REG_AXIS_ORDER:  m_axis = value[2:0];
      qte_pkg::REG_FLIP_ROLL:   m_flip_roll = value[0];
      qte_pkg::REG_FLIP_PITCH:  m_flip_pitch = value[0];
      qte_pkg::REG_FLIP_YAW:    m_flip_yaw = value[0];
      qte_pkg::REG_INVERT_BAND: m_band = value;
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_mounting(logic [2:0] axis, logic fr, logic fp, logic fy,
                              logic [10:0] band);
    drain();
    write_reg(qte_pkg::REG_AXIS_ORDER, {8'd0, axis});
    write_reg(qte_pkg::REG_FLIP_ROLL, {10'd0, fr});
    write_reg(qte_pkg::REG_FLIP_PITCH, {10'd0, fp});
    write_reg(qte_pkg::REG_FLIP_YAW, {10'd0, fy});
    write_reg(qte_pkg::REG_INVERT_BAND, band);
  endtask

  // Extremes, zero cases, negative denominators, saturated pitch, inversion
  task automatic test_directed();
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
    send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
    send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
    send_quat(16'sd100, 16'sd0, 16'sd100, 16'sd1);
    send_quat(16'sd0, 16'sd1, 16'sd0, 16'sd0);
    send_quat(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, -16'sd16384, 16'sd1, 16'sd0);
    send_euler(179.0, 0.0, 0.0, 16384.0);
    send_euler(-179.0, 30.0, 120.0, 16384.0);
    send_euler(91.0, 0.0, 0.0, 16384.0);
    send_euler(93.0, 0.0, 0.0, 16384.0);
    send_euler(91.0, 0.0, 0.0, 16384.0);
    send_euler(87.0, 0.0, 0.0, 16384.0);
    send_euler(0.0, 89.9, 45.0, 16384.0);
    send_euler(0.0, -89.9, -45.0, 16384.0);
    send_euler(10.0, 20.0, 180.0, 30000.0);
  endtask

  // Random mix: rotations, rotations near the inversion band, and raw words
  task automatic test_random(int count);
    int p;
    real v[4], norm;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        norm = 0.0;
        for (int c = 0; c < 4; c++) begin
          v[c] = $itor($urandom_range(0, 20000)) - 10000.0;
          norm = norm + v[c] * v[c];
        end
        if (norm < 1.0) norm = 1.0;
        norm = $sqrt(norm);
        send_quat(16'($rtoi(v[0] / norm * 16384.0)), 16'($rtoi(v[1] / norm * 16384.0)),
                  16'($rtoi(v[2] / norm * 16384.0)), 16'($rtoi(v[3] / norm * 16384.0)));
      end else if (p < 70) begin
        send_euler($itor($urandom_range(0, 7200)) / 20.0 - 180.0,
                   $itor($urandom_range(0, 3600)) / 20.0 - 90.0,
                   $itor($urandom_range(0, 7200)) / 20.0 - 180.0,
                   $itor($urandom_range(4000, 32000)));
      end else if (p < 85) begin
        // hover around ninety degrees on one axis to work the hysteresis
        if ($urandom_range(0, 1))
          send_euler(($urandom_range(0, 1) ? 1.0 : -1.0) *
                     (80.0 + $itor($urandom_range(0, 2000)) / 100.0),
                     $itor($urandom_range(0, 20)) - 10.0, $itor($urandom_range(0, 360)),
                     16384.0);
        else
          send_euler($itor($urandom_range(0, 20)) - 10.0,
                     ($urandom_range(0, 1) ? 1.0 : -1.0) *
                     (86.0 + $itor($urandom_range(0, 400)) / 100.0),
                     $itor($urandom_range(0, 360)), 16384.0);
      end else begin
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  // Walk through the mounting settings, extremes included
  task automatic test_mountings();
    set_mounting(qte_pkg::AX_XZY, 1'b1, 1'b0, 1'b0, 11'd0);
    test_random(200);
    set_mounting(qte_pkg::AX_YXZ, 1'b0, 1'b1, 1'b0, 11'd1024);
    test_random(200);
    set_mounting(qte_pkg::AX_YZX, 1'b0, 1'b0, 1'b1, 11'd64);
    quiet_sender = 1'b1;
    test_random(200);
    quiet_sender = 1'b0;
    set_mounting(qte_pkg::AX_ZXY, 1'b1, 1'b1, 1'b1, 11'd2047);
    test_random(150);
    set_mounting(qte_pkg::AX_ZYX, 1'b1, 1'b0, 1'b1, 11'd200);
    quiet_receiver = 1'b1;
    test_random(200);
    quiet_receiver = 1'b0;
    set_mounting(3'd6, 1'b0, 1'b1, 1'b1, 11'd5);
    test_random(100);
    set_mounting(3'd7, 1'b0, 1'b0, 1'b0, 11'd128);
    write_reg(3'd5, 11'h7FF);
    test_random(100);
    set_mounting(qte_pkg::AX_XYZ, 1'b0, 1'b0, 1'b0, 11'd128);
    test_random(526);
  endtask

  // Random output stall, switched off in quiet stretches
  initial begin
    int g;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (quiet_receiver) begin
        out_stall = 1'b0;
      end else begin
        g = gap_cycles();
        out_stall = (g != 0);
        repeat ((g > 0) ? g - 1 : 0) @(negedge clk);
        if (g != 0) begin
          @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    mount_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_mounts.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        e = expected_mounts.pop_front();
        checked_items++;
        if (roll_angle !== e.roll) begin
          $error("roll_angle: expected %0d, got %0d", e.roll, roll_angle);
          errors++;
        end
        if (pitch_angle !== e.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", e.pitch, pitch_angle);
          errors++;
        end
        if (yaw_angle !== e.yaw) begin
          $error("yaw_angle: expected %0d, got %0d", e.yaw, yaw_angle);
          errors++;
        end
        if (heading_angle !== e.head) begin
          $error("heading_angle: expected %0d, got %0d", e.head, heading_angle);
          errors++;
        end
        if (upside_down !== e.inv) begin
          $error("upside_down: expected %0d, got %0d", e.inv, upside_down);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_mounts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    quat_real = '0; quat_i = '0; quat_j = '0; quat_k = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0; sent_items = 0; checked_items = 0; config_writes = 0; idle_cycles = 0;
    quiet_sender = 1'b0; quiet_receiver = 1'b0;
    m_axis = '0; m_flip_roll = 1'b0; m_flip_pitch = 1'b0; m_flip_yaw = 1'b0;
    m_band = 11'd128; m_inverted = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_mountings();
    drain();

    if (expected_mounts.size() != 0) errors++;
    $display("Covered %0d quaternions, %0d results checked, %0d register writes",
             sent_items, checked_items, config_writes);
    $display("over all axis orders, sign flips and inversion bands from 0 to 2047");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
